FILE: sv/scfd_pkg.sv
// ----------------------------------------------------------------------------
// scfd_pkg: shared types and constants for the command frame deframer
// Buffer size, register codes, frame classes, controller states and the
// control bundle that drives the byte cell chain.
// ----------------------------------------------------------------------------
package scfd_pkg;

    // frame store depth in bytes (4 to 15: the output length field is 4 bits wide)
    localparam int BUFFER_BYTES = 10;

    // fill counter width: holds BUFFER_BYTES itself, at least the 4 output bits
    localparam int FILL_W = ($clog2(BUFFER_BYTES + 1) > 4) ? $clog2(BUFFER_BYTES + 1) : 4;

    // store entry whose code selects the frame class
    localparam int CODE_POS = 2;

    typedef logic [FILL_W-1:0] t_fill;

    // register reset values
    localparam logic [7:0]  HEAD_BYTE_RST = 8'hEF;
    localparam logic [15:0] TAIL_WORD_RST = 16'hFEFF;
    localparam logic [7:0]  LOCAL_THR_RST = 8'hE0;
    localparam logic [7:0]  VERSION_RST   = 8'h10;

    // configuration register indexes
    typedef enum logic [7:0] {
        CFG_HEAD_BYTE = 8'd0,
        CFG_TAIL_WORD = 8'd1,
        CFG_LOCAL_THR = 8'd2,
        CFG_VERSION   = 8'd3
    } t_cfg_idx;

    // frame classes
    typedef enum logic [1:0] {
        CLASS_LOCAL   = 2'd0,
        CLASS_VERSION = 2'd1,
        CLASS_REMOTE  = 2'd2
    } t_class;

    // controller states
    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

    // control bundle for the cell chain
    typedef struct packed {
        logic  load;   // write the request byte into the cell at pos
        t_fill pos;    // store position of the byte
        logic  shift;  // cells take their upper neighbor's byte, the top one holds
    } t_chain_ctl;

endpackage

FILE: sv/scfd_cell.sv
// ----------------------------------------------------------------------------
// scfd_cell: one byte cell of the frame store chain
// Loads the incoming byte when its position is addressed, and takes its
// upper neighbor's byte when the chain shifts toward the output end.
// ----------------------------------------------------------------------------
module scfd_cell (
    input  logic                i_clk,
    input  scfd_pkg::t_chain_ctl i_ctl,
    input  scfd_pkg::t_fill     i_cell_idx,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_next,
    output logic [7:0]          o_data
);

    logic [7:0] r_data;

    // byte storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.pos == i_cell_idx)) begin
            r_data <= i_byte;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

FILE: sv/scfd_ctrl.sv
// ----------------------------------------------------------------------------
// scfd_ctrl: frame controller of the command frame deframer
// Holds the registers, hunts for the head byte, tracks fill position and
// the tail window, classifies the frame and drains the cell chain into the
// output register.
// ----------------------------------------------------------------------------
module scfd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_addr,
    input  logic [15:0]          i_cfg_data,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    // cell chain
    output scfd_pkg::t_chain_ctl o_chain,
    input  logic [7:0]           i_cell0_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic [3:0]           o_out_idx,
    output logic [3:0]           o_out_len,
    output logic [1:0]           o_out_class,
    output logic                 o_out_last
);

    // configuration registers
    logic [7:0]  r_head_byte;
    logic [15:0] r_tail_word;
    logic [7:0]  r_local_thr;
    logic [7:0]  r_version;

    // frame state
    scfd_pkg::t_state r_state, n_state;
    scfd_pkg::t_fill  r_fill, n_fill;
    logic [15:0]      r_window, n_window;
    scfd_pkg::t_fill  r_len, n_len;
    scfd_pkg::t_fill  r_idx, n_idx;
    logic [7:0]       r_code, n_code;

    // output register
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    scfd_pkg::t_fill  r_out_idx, n_out_idx;
    scfd_pkg::t_fill  r_out_len, n_out_len;
    scfd_pkg::t_class r_out_class, n_out_class;
    logic             r_out_last, n_out_last;

    logic             in_acc;
    logic             hunt_drop;
    logic [15:0]      window_sh;
    logic             drain_go;
    logic             emit_last;
    scfd_pkg::t_class frame_class;
    scfd_pkg::t_chain_ctl chain;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_byte <= scfd_pkg::HEAD_BYTE_RST;
            r_tail_word <= scfd_pkg::TAIL_WORD_RST;
            r_local_thr <= scfd_pkg::LOCAL_THR_RST;
            r_version   <= scfd_pkg::VERSION_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                scfd_pkg::CFG_HEAD_BYTE: r_head_byte <= i_cfg_data[7:0];
                scfd_pkg::CFG_TAIL_WORD: r_tail_word <= i_cfg_data;
                scfd_pkg::CFG_LOCAL_THR: r_local_thr <= i_cfg_data[7:0];
                scfd_pkg::CFG_VERSION:   r_version   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // class from the code byte
    always_comb begin
        if (r_code >= r_local_thr) begin
            frame_class = scfd_pkg::CLASS_LOCAL;
        end else if (r_code == r_version) begin
            frame_class = scfd_pkg::CLASS_VERSION;
        end else begin
            frame_class = scfd_pkg::CLASS_REMOTE;
        end
    end

    assign o_in_ready = (r_state == scfd_pkg::ST_COLLECT);
    assign in_acc     = i_in_valid && o_in_ready;
    assign hunt_drop  = (r_fill == '0) && (i_in_byte != r_head_byte);
    assign window_sh  = {r_window[7:0], i_in_byte};
    assign drain_go   = (r_state == scfd_pkg::ST_DRAIN) && (!r_out_valid || i_out_ready);
    assign emit_last  = (scfd_pkg::t_fill'(r_idx + 1'b1) == r_len);

    // next state, collection and drain
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_window    = r_window;
        n_len       = r_len;
        n_idx       = r_idx;
        n_code      = r_code;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_idx   = r_out_idx;
        n_out_len   = r_out_len;
        n_out_class = r_out_class;
        n_out_last  = r_out_last;
        chain       = '{load: 1'b0, pos: r_fill, shift: 1'b0};

        // result taken by the sink
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            scfd_pkg::ST_COLLECT: begin
                if (in_acc && !hunt_drop) begin
                    // store while there is room
                    if (r_fill < scfd_pkg::t_fill'(scfd_pkg::BUFFER_BYTES)) begin
                        chain.load = 1'b1;
                        n_fill     = scfd_pkg::t_fill'(r_fill + 1'b1);
                        if (r_fill == scfd_pkg::t_fill'(scfd_pkg::CODE_POS)) begin
                            n_code = i_in_byte;
                        end
                    end
                    n_window = window_sh;
                    // tail seen: drain the stored bytes
                    if (window_sh == r_tail_word) begin
                        n_len    = n_fill;
                        n_idx    = '0;
                        n_fill   = '0;
                        n_window = '0;
                        n_state  = scfd_pkg::ST_DRAIN;
                    end
                end
            end
            scfd_pkg::ST_DRAIN: begin
                if (drain_go) begin
                    chain.shift = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = i_cell0_data;
                    n_out_idx   = r_idx;
                    n_out_len   = r_len;
                    n_out_class = frame_class;
                    n_out_last  = emit_last;
                    n_idx       = scfd_pkg::t_fill'(r_idx + 1'b1);
                    if (emit_last) begin
                        n_state = scfd_pkg::ST_COLLECT;
                    end
                end
            end
            default: n_state = scfd_pkg::ST_COLLECT;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scfd_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_window    <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_window    <= n_window;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code      <= n_code;
        r_out_byte  <= n_out_byte;
        r_out_idx   <= n_out_idx;
        r_out_len   <= n_out_len;
        r_out_class <= n_out_class;
        r_out_last  <= n_out_last;
    end

    assign o_chain     = chain;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_idx   = r_out_idx[3:0];
    assign o_out_len   = r_out_len[3:0];
    assign o_out_class = r_out_class;
    assign o_out_last  = r_out_last;

    // fill position never passes the buffer size
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= scfd_pkg::t_fill'(scfd_pkg::BUFFER_BYTES))
        else $error("fill position beyond buffer size");

    // a drain starts from a cleared position and window
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == scfd_pkg::ST_DRAIN) |->
            (r_idx == '0) && (r_fill == '0) && (r_window == '0) && (r_len != '0))
        else $error("drain started with stale frame state");

    // drain index stays inside the frame
    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scfd_pkg::ST_DRAIN) |-> (r_idx < r_len))
        else $error("drain index beyond frame length");

    // the last result carries the final index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (scfd_pkg::t_fill'(r_out_idx + 1'b1) == r_out_len))
        else $error("last flag on wrong byte index");

endmodule

FILE: sv/serial_command_frame_deframer.sv
// ----------------------------------------------------------------------------
// serial_command_frame_deframer: head/tail delimited command frame deframer
// Collects received bytes from the head byte on, detects the tail word and
// sends the stored frame out byte by byte with index, length and class.
// ----------------------------------------------------------------------------
// While collecting, the block takes one received byte per clock. Bytes are
// dropped until the head byte arrives; from then on up to BUFFER_BYTES of
// them are stored in a chain of byte cells, and every byte goes through the
// 16-bit tail window. When the window matches the tail word the input is
// held off and the frame leaves through the output register at one byte per
// clock while the sink keeps up, one cell shift per result, and the next
// received byte is taken only once every stored byte has been sent.
// Each result carries the byte, its index, the frame length (capped at the
// buffer size) and a class from stored byte 2: local setting command,
// version read, or forward to the remote parser. Registers are written over
// the configuration channel, index 0 head byte, 1 tail word, 2 local command
// threshold, 3 version code; writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module serial_command_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // byte stream in
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // frame stream out
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] frame_byte, [11:8] byte_index, [15:12] frame_length
    output logic [1:0]  o_m_tuser,   // [1:0] frame_class
    output logic        o_m_tlast
);

    scfd_pkg::t_chain_ctl chain;
    logic [7:0] cell_data [scfd_pkg::BUFFER_BYTES];
    logic [7:0] out_byte;
    logic [3:0] out_idx;
    logic [3:0] out_len;

    // frame controller
    scfd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_in_byte    (i_s_tdata),
        .o_chain      (chain),
        .i_cell0_data (cell_data[0]),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_out_byte   (out_byte),
        .o_out_idx    (out_idx),
        .o_out_len    (out_len),
        .o_out_class  (o_m_tuser),
        .o_out_last   (o_m_tlast)
    );

    // frame store: row of byte cells shifting toward cell 0
    for (genvar k = 0; k < scfd_pkg::BUFFER_BYTES; k++) begin : g_cell
        logic [7:0] next_data;

        if (k == scfd_pkg::BUFFER_BYTES - 1) begin : g_end
            assign next_data = cell_data[k];
        end else begin : g_mid
            assign next_data = cell_data[k+1];
        end

        scfd_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (chain),
            .i_cell_idx (scfd_pkg::t_fill'(k)),
            .i_byte     (i_s_tdata),
            .i_next     (next_data),
            .o_data     (cell_data[k])
        );
    end

    assign o_m_tdata = {out_len, out_idx, out_byte};

endmodule
